FILE: hdl/tfc_pkg.sv
`timescale 1ns / 1ps
package tfc_pkg;

  // Operation codes carried on the mode port
  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_REM = 2'd2,
    MODE_CLR = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // write the new word into the cell at the tail
    logic deq;    // shift every cell down by one
    logic rem;    // shift the cells from the first match upwards
  } cell_ctl_t;

endpackage

FILE: hdl/task_fifo_with_cancel_by_id_unit.sv
`timescale 1ns / 1ps
// Bounded task queue, oldest first, with removal of an entry by its id.
// Command channel: drive mode, task_handle, cancel_kind and target_id and raise
// start; the word is taken at the clock edge where start is high and busy low.
// Modes: enqueue (returns a fresh nonzero id), dequeue (returns the oldest
// entry), remove by id (returns the oldest entry with that id, order of the
// rest kept), clear (empties the queue, the id counter is kept).
// Result channel: done is high for exactly one cycle, the cycle after the
// command is taken, with status, task_id, handle_out, kind_out and entries.
// A new command may follow in every cycle while busy is low: the
// entries sit in a chain of DEPTH cells that compare every id at once and
// collapse the gap in the same cycle, with the match ripple along the chain
// setting the cycle time.
// The receiver cannot hold results off; each result must be taken as shown.
// Reset (rst, synchronous) empties the queue and sets the id counter to zero;
// busy is high while rst is held, and no result is produced for that time.
module task_fifo_with_cancel_by_id_unit #(
  parameter int DEPTH        = 16,
  parameter int ID_WIDTH     = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [HANDLE_WIDTH-1:0]        task_handle,
  input  logic [1:0]                     cancel_kind,
  input  logic [ID_WIDTH-1:0]            target_id,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [ID_WIDTH-1:0]            task_id,
  output logic [HANDLE_WIDTH-1:0]        handle_out,
  output logic [1:0]                     kind_out,
  output logic [$clog2(DEPTH+1)-1:0]     entries
);
  import tfc_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  mode_t                   op;
  logic                    accept;
  logic [OCC_W-1:0]        occupancy;
  logic [OCC_W-1:0]        occupancy_next;
  logic [ID_WIDTH-1:0]     last_id;
  logic [ID_WIDTH-1:0]     last_id_next;
  logic [ID_WIDTH-1:0]     id_sum;
  logic [ID_WIDTH-1:0]     id_inc;
  cell_ctl_t               ctl;
  cell_ctl_t               ctl_gated;
  status_t                 status_next;
  logic [ID_WIDTH-1:0]     task_id_next;
  logic [HANDLE_WIDTH-1:0] handle_out_next;
  logic [1:0]              kind_out_next;

  // Chain links, one more than cells so the ends can be tied off
  logic [HANDLE_WIDTH-1:0] c_handle      [DEPTH+1];
  logic [ID_WIDTH-1:0]     c_id          [DEPTH+1];
  logic [1:0]              c_kind        [DEPTH+1];
  logic                    c_found       [DEPTH+1];
  logic [HANDLE_WIDTH-1:0] c_pick_handle [DEPTH+1];
  logic [ID_WIDTH-1:0]     c_pick_id     [DEPTH+1];
  logic [1:0]              c_pick_kind   [DEPTH+1];

  assign op     = mode_t'(mode);
  assign busy   = rst;
  assign accept = start && !busy;

  // Next id: wrap and skip zero
  assign id_sum = last_id + ID_WIDTH'(1);
  assign id_inc = (id_sum == '0) ? ID_WIDTH'(1) : id_sum;

  // Tie off the ends of the chain
  assign c_handle[DEPTH]  = '0;
  assign c_id[DEPTH]      = '0;
  assign c_kind[DEPTH]    = 2'b00;
  assign c_found[0]       = 1'b0;
  assign c_pick_handle[0] = '0;
  assign c_pick_id[0]     = '0;
  assign c_pick_kind[0]   = 2'b00;

  assign ctl_gated = accept ? ctl : '0;

  // Row of slot cells, oldest at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occupied;
    logic at_tail;

    assign occupied = OCC_W'(i) < occupancy;
    assign at_tail  = OCC_W'(i) == occupancy;

    tfc_cell #(
      .ID_WIDTH     (ID_WIDTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_cell (
      .clk             (clk),
      .ctl             (ctl_gated),
      .occupied        (occupied),
      .at_tail         (at_tail),
      .target          (target_id),
      .new_handle      (task_handle),
      .new_id          (id_inc),
      .new_kind        (cancel_kind),
      .up_handle       (c_handle[i+1]),
      .up_id           (c_id[i+1]),
      .up_kind         (c_kind[i+1]),
      .found_in        (c_found[i]),
      .pick_handle_in  (c_pick_handle[i]),
      .pick_id_in      (c_pick_id[i]),
      .pick_kind_in    (c_pick_kind[i]),
      .handle          (c_handle[i]),
      .id              (c_id[i]),
      .kind            (c_kind[i]),
      .found_out       (c_found[i+1]),
      .pick_handle_out (c_pick_handle[i+1]),
      .pick_id_out     (c_pick_id[i+1]),
      .pick_kind_out   (c_pick_kind[i+1])
    );
  end

  // Decode the command into cell control, counters and the result word
  always_comb begin
    ctl             = '0;
    status_next     = ST_OK;
    task_id_next    = '0;
    handle_out_next = '0;
    kind_out_next   = 2'b00;
    occupancy_next  = occupancy;
    last_id_next    = last_id;
    case (op)
      MODE_ENQ: begin
        if (task_handle == '0) begin
          status_next = ST_INVALID;
        end else if (occupancy == OCC_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ctl.load       = 1'b1;
          last_id_next   = id_inc;
          task_id_next   = id_inc;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end
      MODE_DEQ: begin
        if (occupancy == '0) begin
          status_next = ST_NOTFOUND;
        end else begin
          ctl.deq         = 1'b1;
          task_id_next    = c_id[0];
          handle_out_next = c_handle[0];
          kind_out_next   = c_kind[0];
          occupancy_next  = occupancy - OCC_W'(1);
        end
      end
      MODE_REM: begin
        if (target_id == '0) begin
          status_next = ST_INVALID;
        end else if (!c_found[DEPTH]) begin
          status_next = ST_NOTFOUND;
        end else begin
          ctl.rem         = 1'b1;
          task_id_next    = c_pick_id[DEPTH];
          handle_out_next = c_pick_handle[DEPTH];
          kind_out_next   = c_pick_kind[DEPTH];
          occupancy_next  = occupancy - OCC_W'(1);
        end
      end
      MODE_CLR: begin
        occupancy_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Hold the fill count and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      last_id   <= '0;
      done      <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        occupancy <= occupancy_next;
        last_id   <= last_id_next;
      end
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      task_id    <= task_id_next;
      handle_out <= handle_out_next;
      kind_out   <= kind_out_next;
      entries    <= occupancy_next;
    end
  end

endmodule

FILE: hdl/tfc_cell.sv
`timescale 1ns / 1ps
module tfc_cell #(
  parameter int ID_WIDTH     = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                    clk,
  input  tfc_pkg::cell_ctl_t      ctl,
  input  logic                    occupied,
  input  logic                    at_tail,
  input  logic [ID_WIDTH-1:0]     target,
  input  logic [HANDLE_WIDTH-1:0] new_handle,
  input  logic [ID_WIDTH-1:0]     new_id,
  input  logic [1:0]              new_kind,
  input  logic [HANDLE_WIDTH-1:0] up_handle,
  input  logic [ID_WIDTH-1:0]     up_id,
  input  logic [1:0]              up_kind,
  input  logic                    found_in,
  input  logic [HANDLE_WIDTH-1:0] pick_handle_in,
  input  logic [ID_WIDTH-1:0]     pick_id_in,
  input  logic [1:0]              pick_kind_in,
  output logic [HANDLE_WIDTH-1:0] handle,
  output logic [ID_WIDTH-1:0]     id,
  output logic [1:0]              kind,
  output logic                    found_out,
  output logic [HANDLE_WIDTH-1:0] pick_handle_out,
  output logic [ID_WIDTH-1:0]     pick_id_out,
  output logic [1:0]              pick_kind_out
);
  import tfc_pkg::*;

  logic hit;
  logic first;
  logic shift;

  // Match the target against this slot and extend the found chain
  assign hit       = occupied && (id == target);
  assign first     = hit && !found_in;
  assign found_out = found_in || hit;
  assign shift     = ctl.deq || (ctl.rem && found_out);

  // Pass the first matching word towards the end of the chain
  assign pick_handle_out = pick_handle_in | (first ? handle : '0);
  assign pick_id_out     = pick_id_in     | (first ? id     : '0);
  assign pick_kind_out   = pick_kind_in   | (first ? kind   : 2'b00);

  // Load at the tail, or take the younger neighbour's word on a shift
  always_ff @(posedge clk) begin
    if (ctl.load && at_tail) begin
      handle <= new_handle;
      id     <= new_id;
      kind   <= new_kind;
    end else if (shift) begin
      handle <= up_handle;
      id     <= up_id;
      kind   <= up_kind;
    end
  end

endmodule
